// ===== rtl/core/jsva_pkg.sv =====
// Types and constants shared by the jog switch value adjuster files.
`default_nettype none

package jsva_pkg;

  localparam int unsigned LevelW    = 8;
  localparam int unsigned BarW      = 6;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  // divide-by-5 reciprocal, exact for any 8-bit value
  localparam int unsigned Div5Mul   = 205;
  localparam int unsigned Div5Shift = 10;

  localparam logic [LevelW-1:0]    RstMinValue   = 8'd0;
  localparam logic [LevelW-1:0]    RstMaxValue   = 8'd100;
  localparam logic [IntervalW-1:0] RstFirstDelay = 16'd500;
  localparam logic [IntervalW-1:0] RstRepeat     = 16'd50;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_VALUE   = 8'd0,
    REG_MAX_VALUE   = 8'd1,
    REG_FIRST_DELAY = 8'd2,
    REG_REPEAT      = 8'd3
  } jsva_reg_t;

  typedef struct packed {
    logic             far_left_n;
    logic             near_left_n;
    logic             far_right_n;
    logic             near_right_n;
    logic             toggle_n;
    logic [TimeW-1:0] now_ms;
  } jsva_in_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [BarW-1:0]   bar_position;
    logic              toggle_on;
  } jsva_out_t;

  typedef struct packed {
    logic [LevelW-1:0]    min_value;
    logic [LevelW-1:0]    max_value;
    logic [IntervalW-1:0] first_delay_ms;
    logic [IntervalW-1:0] repeat_ms;
  } jsva_cfg_t;

  typedef struct packed {
    logic [LevelW-1:0]    level;
    logic [TimeW-1:0]     last_change_ms;
    logic [IntervalW-1:0] interval;
    logic                 left_latched;
    logic                 right_latched;
  } jsva_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/jsva_step.sv =====
// Next-state and result logic for one switch sample.
`default_nettype none

module jsva_step (
  input  jsva_pkg::jsva_in_t    smp,
  input  jsva_pkg::jsva_cfg_t   cfg,
  input  jsva_pkg::jsva_state_t st,
  output jsva_pkg::jsva_state_t st_nxt,
  output jsva_pkg::jsva_out_t   res
);
  import jsva_pkg::*;

  logic [TimeW-1:0]    elapsed;
  logic                far_due;
  logic                can_down;
  logic                can_up;
  logic [LevelW-1:0]   lvl_dn;
  logic [LevelW-1:0]   lvl_up;
  logic [LevelW+10:0]  bar_prod;

  assign elapsed  = smp.now_ms - st.last_change_ms;
  assign far_due  = elapsed > {{(TimeW-IntervalW){1'b0}}, st.interval};
  assign can_down = st.level > cfg.min_value;
  assign can_up   = st.level < cfg.max_value;
  assign lvl_dn   = st.level - LevelW'(1);
  assign lvl_up   = st.level + LevelW'(1);

  always_comb begin
    st_nxt = st;
    priority if (!smp.far_left_n) begin
      if (far_due && can_down) begin
        st_nxt.level          = lvl_dn;
        st_nxt.last_change_ms = smp.now_ms;
        st_nxt.interval       = cfg.repeat_ms;
      end
    end else if (!smp.near_left_n) begin
      if (!st.left_latched) begin
        st_nxt.left_latched = 1'b1;
        if (can_down) begin
          st_nxt.level          = lvl_dn;
          st_nxt.last_change_ms = smp.now_ms;
        end
      end
    end else if (!smp.far_right_n) begin
      if (far_due && can_up) begin
        st_nxt.level          = lvl_up;
        st_nxt.last_change_ms = smp.now_ms;
        st_nxt.interval       = cfg.repeat_ms;
      end
    end else if (!smp.near_right_n) begin
      if (!st.right_latched) begin
        st_nxt.right_latched = 1'b1;
        if (can_up) begin
          st_nxt.level          = lvl_up;
          st_nxt.last_change_ms = smp.now_ms;
        end
      end
    end else begin
      // all jog contacts open
      st_nxt.left_latched  = 1'b0;
      st_nxt.right_latched = 1'b0;
      st_nxt.interval      = cfg.first_delay_ms;
    end
  end

  assign bar_prod = st_nxt.level * (LevelW+11)'(Div5Mul);

  always_comb begin
    res.level        = st_nxt.level;
    res.bar_position = bar_prod[Div5Shift +: BarW];
    res.toggle_on    = ~smp.toggle_n;
  end

endmodule

`default_nettype wire

// ===== rtl/core/jog_switch_value_adjuster_unit.sv =====
// Top level of the jog switch value adjuster.
//
// Usage: each request on the in_ channel is one sample of the five active-low
// contacts plus a millisecond timestamp. Every request produces exactly one
// result on the out_ channel: the adjusted level, level/5 and the toggle state.
// Samples are registered, then one pass of step logic updates the counter
// state and writes the result register, so a result passes through the input
// register and then the result register. Throughput is one sample per cycle
// while the receiver does not stall; the state (level, timestamp, interval,
// latches) is written in the same cycle as the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; in_ready drops only when both are full.
// cfg_ requests write bounds and intervals; cfg_ready is always high and
// indexes beyond the register list are ignored.
// Reset (rst_n low, synchronous) empties both stages, sets level, timestamp
// and latches to zero, the interval to 500 and the registers to their
// defaults: min 0, max 100, first delay 500, repeat 50.
`default_nettype none

module jog_switch_value_adjuster_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  jsva_pkg::jsva_in_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output jsva_pkg::jsva_out_t                  out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [jsva_pkg::CfgIdxW-1:0]          cfg_index,
  input  wire [jsva_pkg::CfgDataW-1:0]         cfg_data
);
  import jsva_pkg::*;

  logic        smp_vld_r;
  jsva_in_t    smp_r;
  jsva_cfg_t   cfg_r;
  jsva_state_t st_r;
  jsva_state_t st_nxt;
  jsva_out_t   res_nxt;
  jsva_out_t   res_r;
  logic        res_vld_r;
  logic        smp_adv;

  assign smp_adv   = smp_vld_r && (!res_vld_r || out_ready);
  assign in_ready  = !smp_vld_r || smp_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  jsva_step u_step (
    .smp    (smp_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      st_r      <= '{level: '0, last_change_ms: '0, interval: RstFirstDelay,
                     left_latched: 1'b0, right_latched: 1'b0};
    end else begin
      if (in_ready) smp_vld_r <= in_valid;
      if (smp_adv) begin
        res_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) smp_r <= in_data;
    if (smp_adv) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{min_value: RstMinValue, max_value: RstMaxValue,
                 first_delay_ms: RstFirstDelay, repeat_ms: RstRepeat};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_VALUE:   cfg_r.min_value      <= cfg_data[LevelW-1:0];
        REG_MAX_VALUE:   cfg_r.max_value      <= cfg_data[LevelW-1:0];
        REG_FIRST_DELAY: cfg_r.first_delay_ms <= cfg_data;
        REG_REPEAT:      cfg_r.repeat_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/jsva_chk.sv =====
// Port-level checks for the jog switch value adjuster, bound to the top level.
`default_nettype none

module jsva_chk (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input jsva_pkg::jsva_out_t out_data
);
  import jsva_pkg::*;

  logic [LevelW-1:0] prev_lvl_r;
  logic [LevelW+2:0] bar_x5;
  logic [LevelW+2:0] lvl_ext;

  assign bar_x5  = (LevelW+3)'(out_data.bar_position) * (LevelW+3)'(5);
  assign lvl_ext = (LevelW+3)'(out_data.level);

  always_ff @(posedge clk) begin
    if (!rst_n) prev_lvl_r <= '0;
    else if (out_valid && out_ready) prev_lvl_r <= out_data.level;
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_bar_div5: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bar_x5 <= lvl_ext && lvl_ext < bar_x5 + (LevelW+3)'(5))
    else $error("bar position is not level divided by five");

  a_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.level == prev_lvl_r
               || out_data.level == prev_lvl_r + LevelW'(1)
               || out_data.level == prev_lvl_r - LevelW'(1))
    else $error("level moved by more than one per request");

endmodule

bind jog_switch_value_adjuster_unit jsva_chk u_jsva_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
